@@ rtl/cycle_counter_frequency_scale_unit_defines.svh @@
// Assertion macros shared by the frequency scale unit RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef CYCLE_COUNTER_FREQUENCY_SCALE_UNIT_DEFINES_SVH
`define CYCLE_COUNTER_FREQUENCY_SCALE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define CCFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccfs: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccfs: next-cycle check failed");

// expression must never hold
`define CCFS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ccfs: forbidden condition seen");

`else

`define CCFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define CCFS_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ rtl/ccfs_pkg.sv @@
// Shared types, constants and the microcode program of the frequency scale unit.
// No dependencies.
`default_nettype none

package ccfs_pkg;

    // widths
    localparam int unsigned DIV_W      = 64;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned PC_W       = 5;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    // arithmetic constants
    localparam logic [31:0] KHZ_PER_CYCLE_NS = 32'd1000000;
    localparam logic [10:0] SCALE_ONE        = 11'd1024;
    localparam int unsigned SCALE_SHIFT      = 10;

    // register reset values
    localparam logic [29:0] MULT_RESET    = 30'd625;
    localparam logic [31:0] DIV_RESET     = 32'd12;
    localparam logic [31:0] MIN_WIN_RESET = 32'd1920;
    localparam logic [23:0] MAX_KHZ_RESET = 24'd3302400;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MULT    = 2'd0;
    localparam logic [1:0] REG_DIV     = 2'd1;
    localparam logic [1:0] REG_MIN_WIN = 2'd2;
    localparam logic [1:0] REG_MAX_KHZ = 2'd3;

    // event modes
    localparam logic [2:0] MODE_SAMPLE      = 3'd0;
    localparam logic [2:0] MODE_SAMPLE_EVAL = 3'd1;
    localparam logic [2:0] MODE_EVAL        = 3'd2;
    localparam logic [2:0] MODE_REBASE      = 3'd3;
    localparam logic [2:0] MODE_INIT        = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] cycle_reading;
        logic [63:0] timer_reading;
    } req_t;

    typedef struct packed {
        logic        scale_valid;
        logic [10:0] freq_scale;
        logic [23:0] measured_khz;
    } rsp_t;

    typedef struct packed {
        logic [29:0] mult;
        logic [31:0] div;
        logic [31:0] min_win;
        logic [23:0] max_khz;
    } cfg_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_DELTA,
        OP_STALE_CLR,
        OP_ACCUM,
        OP_MUL_TL,
        OP_MUL_TH,
        OP_MUL_FOLD,
        OP_DIV_NS,
        OP_NS_TAKE,
        OP_MUL_CL,
        OP_MUL_CH,
        OP_DIV_F,
        OP_F_TAKE,
        OP_DIV_S,
        OP_SCALE_TAKE,
        OP_MARK_STALE,
        OP_REBASE,
        OP_INIT
    } dp_op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_SAMPLE_ONLY,
        C_WIN_SHORT,
        C_DIV_ZERO,
        C_DIV_BUSY,
        C_QUO_ZERO
    } cond_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            last;
    } ctl_word_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic win_short;
        logic div_zero;
        logic quo_zero;
        logic div_busy;
    } flags_t;

    // command from sequencer to datapath
    typedef struct packed {
        logic   start;
        dp_op_t op;
    } seq_cmd_t;

    // program step addresses
    localparam logic [PC_W-1:0] ST_DELTA     = 5'd0;
    localparam logic [PC_W-1:0] ST_STALE     = 5'd1;
    localparam logic [PC_W-1:0] ST_ACCUM     = 5'd2;
    localparam logic [PC_W-1:0] ST_EVAL      = 5'd3;
    localparam logic [PC_W-1:0] ST_DIVCHK    = 5'd4;
    localparam logic [PC_W-1:0] ST_MUL_TL    = 5'd5;
    localparam logic [PC_W-1:0] ST_MUL_TH    = 5'd6;
    localparam logic [PC_W-1:0] ST_FOLD_T    = 5'd7;
    localparam logic [PC_W-1:0] ST_DIV_NS    = 5'd8;
    localparam logic [PC_W-1:0] ST_WAIT_NS   = 5'd9;
    localparam logic [PC_W-1:0] ST_NS_TAKE   = 5'd10;
    localparam logic [PC_W-1:0] ST_MUL_CL    = 5'd11;
    localparam logic [PC_W-1:0] ST_MUL_CH    = 5'd12;
    localparam logic [PC_W-1:0] ST_FOLD_C    = 5'd13;
    localparam logic [PC_W-1:0] ST_DIV_F     = 5'd14;
    localparam logic [PC_W-1:0] ST_WAIT_F    = 5'd15;
    localparam logic [PC_W-1:0] ST_F_TAKE    = 5'd16;
    localparam logic [PC_W-1:0] ST_DIV_S     = 5'd17;
    localparam logic [PC_W-1:0] ST_WAIT_S    = 5'd18;
    localparam logic [PC_W-1:0] ST_SCALE     = 5'd19;
    localparam logic [PC_W-1:0] ST_MARK      = 5'd20;
    localparam logic [PC_W-1:0] ST_REBASE    = 5'd21;
    localparam logic [PC_W-1:0] ST_INIT      = 5'd22;
    localparam logic [PC_W-1:0] ST_END       = 5'd23;

    function automatic ctl_word_t cw(input dp_op_t op, input cond_t cond,
                                     input logic [PC_W-1:0] target, input logic last);
        ctl_word_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // microcode program
    function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        case (pc)
            ST_DELTA:   w = cw(OP_DELTA,      C_NEVER,       ST_END,     1'b0);
            ST_STALE:   w = cw(OP_STALE_CLR,  C_NEVER,       ST_END,     1'b0);
            ST_ACCUM:   w = cw(OP_ACCUM,      C_SAMPLE_ONLY, ST_END,     1'b0);
            ST_EVAL:    w = cw(OP_NOP,        C_WIN_SHORT,   ST_MARK,    1'b0);
            ST_DIVCHK:  w = cw(OP_NOP,        C_DIV_ZERO,    ST_END,     1'b0);
            ST_MUL_TL:  w = cw(OP_MUL_TL,     C_NEVER,       ST_END,     1'b0);
            ST_MUL_TH:  w = cw(OP_MUL_TH,     C_NEVER,       ST_END,     1'b0);
            ST_FOLD_T:  w = cw(OP_MUL_FOLD,   C_NEVER,       ST_END,     1'b0);
            ST_DIV_NS:  w = cw(OP_DIV_NS,     C_NEVER,       ST_END,     1'b0);
            ST_WAIT_NS: w = cw(OP_NOP,        C_DIV_BUSY,    ST_WAIT_NS, 1'b0);
            ST_NS_TAKE: w = cw(OP_NS_TAKE,    C_QUO_ZERO,    ST_END,     1'b0);
            ST_MUL_CL:  w = cw(OP_MUL_CL,     C_NEVER,       ST_END,     1'b0);
            ST_MUL_CH:  w = cw(OP_MUL_CH,     C_NEVER,       ST_END,     1'b0);
            ST_FOLD_C:  w = cw(OP_MUL_FOLD,   C_NEVER,       ST_END,     1'b0);
            ST_DIV_F:   w = cw(OP_DIV_F,      C_NEVER,       ST_END,     1'b0);
            ST_WAIT_F:  w = cw(OP_NOP,        C_DIV_BUSY,    ST_WAIT_F,  1'b0);
            ST_F_TAKE:  w = cw(OP_F_TAKE,     C_NEVER,       ST_END,     1'b0);
            ST_DIV_S:   w = cw(OP_DIV_S,      C_NEVER,       ST_END,     1'b0);
            ST_WAIT_S:  w = cw(OP_NOP,        C_DIV_BUSY,    ST_WAIT_S,  1'b0);
            ST_SCALE:   w = cw(OP_SCALE_TAKE, C_ALWAYS,      ST_END,     1'b0);
            ST_MARK:    w = cw(OP_MARK_STALE, C_ALWAYS,      ST_END,     1'b0);
            ST_REBASE:  w = cw(OP_REBASE,     C_ALWAYS,      ST_END,     1'b0);
            ST_INIT:    w = cw(OP_INIT,       C_ALWAYS,      ST_END,     1'b0);
            default:    w = cw(OP_NOP,        C_NEVER,       ST_END,     1'b1);
        endcase
        return w;
    endfunction

    // first step for each mode
    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] mode);
        logic [PC_W-1:0] pc;
        case (mode)
            MODE_SAMPLE:      pc = ST_DELTA;
            MODE_SAMPLE_EVAL: pc = ST_DELTA;
            MODE_EVAL:        pc = ST_EVAL;
            MODE_REBASE:      pc = ST_REBASE;
            MODE_INIT:        pc = ST_INIT;
            default:          pc = ST_END;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ccfs_div.sv @@
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on ccfs_pkg for widths.
`default_nettype none

module ccfs_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ccfs_pkg::DIV_W-1:0]  num,
    input  wire logic [ccfs_pkg::DIV_W-1:0]  den,
    output logic                             busy,
    output logic [ccfs_pkg::DIV_W-1:0]       quo
);

    localparam logic [ccfs_pkg::CNT_W-1:0] CNT_LAST = ccfs_pkg::CNT_W'(ccfs_pkg::DIV_W - 1);
    localparam logic [ccfs_pkg::CNT_W-1:0] CNT_ONE  = ccfs_pkg::CNT_W'(1);

    logic [ccfs_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [ccfs_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [ccfs_pkg::DIV_W-1:0] den_reg;
    logic [ccfs_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;

    logic [ccfs_pkg::DIV_W:0] trial;
    logic [ccfs_pkg::DIV_W:0] diff;

    // one trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[ccfs_pkg::DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[ccfs_pkg::DIV_W])
        begin
            rem_next = diff[ccfs_pkg::DIV_W-1:0];
            quo_next = {quo_reg[ccfs_pkg::DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[ccfs_pkg::DIV_W-1:0];
            quo_next = {quo_reg[ccfs_pkg::DIV_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_ONE;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

@@ rtl/ccfs_dp.sv @@
// Datapath: counter state, accumulators, shared multiplier and divider.
// Depends on ccfs_pkg and ccfs_div.
`default_nettype none

module ccfs_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ccfs_pkg::seq_cmd_t cmd,
    input  wire ccfs_pkg::req_t     req,
    input  wire ccfs_pkg::cfg_t     cfg,
    output ccfs_pkg::flags_t        flags,
    output ccfs_pkg::rsp_t          result
);

    // architectural state
    logic [63:0] last_cycles_reg, last_cycles_next;
    logic [63:0] last_ticks_reg,  last_ticks_next;
    logic [63:0] sum_cycles_reg,  sum_cycles_next;
    logic [63:0] sum_ticks_reg,   sum_ticks_next;
    logic        stale_reg,       stale_next;
    logic [10:0] last_scale_reg,  last_scale_next;
    logic        sv_reg,          sv_next;

    // working registers
    logic [63:0] cyc_reg;
    logic [63:0] tim_reg;
    logic [63:0] dc_reg,    dc_next;
    logic [63:0] dt_reg,    dt_next;
    logic [63:0] acc_reg,   acc_next;
    logic [63:0] mprod_reg, mprod_next;
    logic [63:0] ns_reg,    ns_next;
    logic [23:0] f_reg,     f_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        div_start;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic        div_busy;
    logic [63:0] div_quo;

    logic [63:0] min_win_ext;
    logic [63:0] max_ext;

    assign min_win_ext = {32'd0, cfg.min_win};
    assign max_ext     = {40'd0, cfg.max_khz};

    ccfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // shared 32x32 multiplier operand select
    always_comb
    begin
        case (cmd.op)
            ccfs_pkg::OP_MUL_TL:
            begin
                mul_a = sum_ticks_reg[31:0];
                mul_b = {2'b00, cfg.mult};
            end
            ccfs_pkg::OP_MUL_TH:
            begin
                mul_a = sum_ticks_reg[63:32];
                mul_b = {2'b00, cfg.mult};
            end
            ccfs_pkg::OP_MUL_CL:
            begin
                mul_a = sum_cycles_reg[31:0];
                mul_b = ccfs_pkg::KHZ_PER_CYCLE_NS;
            end
            default:
            begin
                mul_a = sum_cycles_reg[63:32];
                mul_b = ccfs_pkg::KHZ_PER_CYCLE_NS;
            end
        endcase
        mprod_next = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = acc_reg;
        div_den   = {32'd0, cfg.div};
        case (cmd.op)
            ccfs_pkg::OP_DIV_NS:
            begin
                div_start = 1'b1;
            end
            ccfs_pkg::OP_DIV_F:
            begin
                div_start = 1'b1;
                div_den   = ns_reg;
            end
            ccfs_pkg::OP_DIV_S:
            begin
                div_start = 1'b1;
                div_num   = {30'd0, f_reg, {ccfs_pkg::SCALE_SHIFT{1'b0}}};
                div_den   = max_ext;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // next-state per operation
    always_comb
    begin
        last_cycles_next = last_cycles_reg;
        last_ticks_next  = last_ticks_reg;
        sum_cycles_next  = sum_cycles_reg;
        sum_ticks_next   = sum_ticks_reg;
        stale_next       = stale_reg;
        last_scale_next  = last_scale_reg;
        sv_next          = sv_reg;
        dc_next          = dc_reg;
        dt_next          = dt_reg;
        acc_next         = acc_reg;
        ns_next          = ns_reg;
        f_next           = f_reg;
        if (cmd.start)
        begin
            sv_next = 1'b0;
        end
        case (cmd.op)
            ccfs_pkg::OP_DELTA:
            begin
                dc_next          = cyc_reg - last_cycles_reg;
                dt_next          = tim_reg - last_ticks_reg;
                last_cycles_next = cyc_reg;
                last_ticks_next  = tim_reg;
            end
            ccfs_pkg::OP_STALE_CLR:
            begin
                if (stale_reg && (dt_reg >= min_win_ext))
                begin
                    sum_cycles_next = '0;
                    sum_ticks_next  = '0;
                    stale_next      = 1'b0;
                end
            end
            ccfs_pkg::OP_ACCUM:
            begin
                sum_cycles_next = sum_cycles_reg + dc_reg;
                sum_ticks_next  = sum_ticks_reg + dt_reg;
            end
            ccfs_pkg::OP_MUL_TH, ccfs_pkg::OP_MUL_CH:
            begin
                acc_next = mprod_reg;
            end
            ccfs_pkg::OP_MUL_FOLD:
            begin
                // high partial product only matters below bit 64
                acc_next = acc_reg + {mprod_reg[31:0], 32'd0};
            end
            ccfs_pkg::OP_NS_TAKE:
            begin
                ns_next = div_quo;
            end
            ccfs_pkg::OP_F_TAKE:
            begin
                if (div_quo > max_ext)
                begin
                    f_next = cfg.max_khz;
                end
                else
                begin
                    f_next = div_quo[23:0];
                end
            end
            ccfs_pkg::OP_SCALE_TAKE:
            begin
                if (cfg.max_khz == '0)
                begin
                    last_scale_next = '0;
                end
                else
                begin
                    last_scale_next = div_quo[10:0];
                end
                sv_next         = 1'b1;
                sum_cycles_next = '0;
                sum_ticks_next  = '0;
                stale_next      = 1'b0;
            end
            ccfs_pkg::OP_MARK_STALE:
            begin
                if (sum_ticks_reg != '0)
                begin
                    stale_next = 1'b1;
                end
            end
            ccfs_pkg::OP_REBASE:
            begin
                last_cycles_next = cyc_reg;
                last_ticks_next  = tim_reg;
            end
            ccfs_pkg::OP_INIT:
            begin
                last_cycles_next = cyc_reg;
                last_ticks_next  = tim_reg;
                sum_cycles_next  = '0;
                sum_ticks_next   = '0;
                stale_next       = 1'b0;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cycles_reg <= '0;
            last_ticks_reg  <= '0;
            sum_cycles_reg  <= '0;
            sum_ticks_reg   <= '0;
            stale_reg       <= 1'b0;
            last_scale_reg  <= ccfs_pkg::SCALE_ONE;
            sv_reg          <= 1'b0;
        end
        else
        begin
            last_cycles_reg <= last_cycles_next;
            last_ticks_reg  <= last_ticks_next;
            sum_cycles_reg  <= sum_cycles_next;
            sum_ticks_reg   <= sum_ticks_next;
            stale_reg       <= stale_next;
            last_scale_reg  <= last_scale_next;
            sv_reg          <= sv_next;
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cyc_reg <= req.cycle_reading;
            tim_reg <= req.timer_reading;
        end
        dc_reg    <= dc_next;
        dt_reg    <= dt_next;
        acc_reg   <= acc_next;
        mprod_reg <= mprod_next;
        ns_reg    <= ns_next;
        f_reg     <= f_next;
    end

    // status to sequencer
    assign flags.win_short = sum_ticks_reg < min_win_ext;
    assign flags.div_zero  = cfg.div == '0;
    assign flags.quo_zero  = div_quo == '0;
    assign flags.div_busy  = div_busy;

    // result fields
    assign result.scale_valid  = sv_reg;
    assign result.freq_scale   = last_scale_reg;
    assign result.measured_khz = sv_reg ? f_reg : 24'd0;

endmodule

`default_nettype wire

@@ rtl/ccfs_seq.sv @@
// Microcode sequencer: step counter, program table and jump logic.
// Depends on ccfs_pkg for the program and control types.
`default_nettype none

module ccfs_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       mode,
    input  wire ccfs_pkg::flags_t flags,
    input  wire logic             out_free,
    output ccfs_pkg::seq_cmd_t    cmd,
    output logic                  running,
    output logic                  finish
);

    localparam logic [ccfs_pkg::PC_W-1:0] PC_ONE = ccfs_pkg::PC_W'(1);

    logic [ccfs_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                      running_reg, running_next;
    logic [2:0]                mode_reg, mode_next;
    ccfs_pkg::ctl_word_t       word;
    logic                      taken;

    assign word = ccfs_pkg::ucode(pc_reg);

    // jump condition select
    always_comb
    begin
        case (word.cond)
            ccfs_pkg::C_NEVER:       taken = 1'b0;
            ccfs_pkg::C_ALWAYS:      taken = 1'b1;
            ccfs_pkg::C_SAMPLE_ONLY: taken = mode_reg == ccfs_pkg::MODE_SAMPLE;
            ccfs_pkg::C_WIN_SHORT:   taken = flags.win_short;
            ccfs_pkg::C_DIV_ZERO:    taken = flags.div_zero;
            ccfs_pkg::C_DIV_BUSY:    taken = flags.div_busy;
            ccfs_pkg::C_QUO_ZERO:    taken = flags.quo_zero;
            default:                 taken = 1'b0;
        endcase
    end

    // step counter
    always_comb
    begin
        pc_next      = pc_reg;
        running_next = running_reg;
        mode_next    = mode_reg;
        if (start)
        begin
            pc_next      = ccfs_pkg::entry_pc(mode);
            running_next = 1'b1;
            mode_next    = mode;
        end
        else if (running_reg)
        begin
            if (word.last)
            begin
                // hold on the final step until the output register frees
                if (out_free)
                begin
                    running_next = 1'b0;
                end
            end
            else if (taken)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + PC_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= ccfs_pkg::ST_END;
            running_reg <= 1'b0;
            mode_reg    <= ccfs_pkg::MODE_SAMPLE;
        end
        else
        begin
            pc_reg      <= pc_next;
            running_reg <= running_next;
            mode_reg    <= mode_next;
        end
    end

    assign cmd.start = start;
    assign cmd.op    = running_reg ? word.op : ccfs_pkg::OP_NOP;
    assign running   = running_reg;
    assign finish    = running_reg && word.last && out_free;

endmodule

`default_nettype wire

@@ rtl/cycle_counter_frequency_scale_unit.sv @@
// Frequency scale unit: takes paired cycle-counter and timer readings, accumulates
// the deltas and reports the core frequency in kHz and a scale where 1024 is full
// speed. One event is in work at a time; the next is taken once the current one
// has finished, while its result may still wait in the output register. A full
// evaluation runs three back-to-back divisions (ns, kHz, scale) in the shared
// one-bit-per-cycle divider. An evaluation stops early if the window is too
// short, the divisor is zero or the ns value is zero. The next event can be taken
// once the result has been loaded into the output register.
// Depends on ccfs_pkg, ccfs_seq, ccfs_dp and the assertion macro header.
`default_nettype none

`include "cycle_counter_frequency_scale_unit_defines.svh"

module cycle_counter_frequency_scale_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ccfs_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [ccfs_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [ccfs_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                      pready,
    // event channel
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire ccfs_pkg::req_t                       req,
    // result channel
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output ccfs_pkg::rsp_t                            rsp
);

    ccfs_pkg::cfg_t     cfg_reg;
    ccfs_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    ccfs_pkg::seq_cmd_t cmd;
    ccfs_pkg::flags_t   flags;
    ccfs_pkg::rsp_t     result;
    logic               running;
    logic               finish;
    logic               accept;
    logic               out_free;
    logic               cfg_write;
    logic [1:0]         reg_idx;
    logic               out_no_scale;

    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mult    <= ccfs_pkg::MULT_RESET;
            cfg_reg.div     <= ccfs_pkg::DIV_RESET;
            cfg_reg.min_win <= ccfs_pkg::MIN_WIN_RESET;
            cfg_reg.max_khz <= ccfs_pkg::MAX_KHZ_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                ccfs_pkg::REG_MULT:    cfg_reg.mult    <= pwdata[29:0];
                ccfs_pkg::REG_DIV:     cfg_reg.div     <= pwdata;
                ccfs_pkg::REG_MIN_WIN: cfg_reg.min_win <= pwdata;
                ccfs_pkg::REG_MAX_KHZ: cfg_reg.max_khz <= pwdata[23:0];
                default:               cfg_reg.div     <= cfg_reg.div;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            ccfs_pkg::REG_MULT:    prdata = {2'b00, cfg_reg.mult};
            ccfs_pkg::REG_DIV:     prdata = cfg_reg.div;
            ccfs_pkg::REG_MIN_WIN: prdata = cfg_reg.min_win;
            ccfs_pkg::REG_MAX_KHZ: prdata = {8'd0, cfg_reg.max_khz};
            default:               prdata = '0;
        endcase
    end

    // event handshake
    assign req_stall = running;
    assign accept    = req_valid && !running;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    ccfs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .mode     (req.mode),
        .flags    (flags),
        .out_free (out_free),
        .cmd      (cmd),
        .running  (running),
        .finish   (finish)
    );

    ccfs_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .cfg    (cfg_reg),
        .flags  (flags),
        .result (result)
    );

    // output register
    always_comb
    begin
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    assign out_no_scale = rsp_valid && !rsp.scale_valid;

    `CCFS_ASSERT_NEXT(a_accept_blocks_next, clk, rst_n, req_valid && !req_stall, req_stall)
    `CCFS_ASSERT_IMPLY(a_khz_zero_when_no_scale, clk, rst_n, out_no_scale, rsp.measured_khz == 24'd0)
    `CCFS_ASSERT_IMPLY(a_scale_in_range, clk, rst_n, rsp_valid, rsp.freq_scale <= ccfs_pkg::SCALE_ONE)
    `CCFS_ASSERT_NEVER(a_finish_while_idle, clk, rst_n, finish && !running)

endmodule

`default_nettype wire
